/* rtl/owig_pkg.sv */
// ----------------------------------------------------------------------------
// owig_pkg
// Shared types, sizes and codes of the occupancy window gain block.
// ----------------------------------------------------------------------------
package owig_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 63;

  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int MAX_SIDE = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int MAX_DIM  = ((MAX_SIDE > 512) ? MAX_SIDE : 512) + MAX_RADIUS;
  localparam int CRD_W    = $clog2(MAX_DIM + 1) + 1;

  localparam int GAIN_W  = 15;
  localparam int MAX_CNT = (2 * MAX_RADIUS + 1) * 2 * MAX_RADIUS;
  localparam int CNT_W   = $clog2(MAX_CNT + 1) + 1;
  localparam int ACC_W   = (CNT_W > GAIN_W) ? CNT_W : GAIN_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [8:0] GRID_WIDTH_RST  = 9'd256;
  localparam logic [8:0] GRID_HEIGHT_RST = 9'd256;
  localparam logic [5:0] RADIUS_RST      = 6'd20;

  localparam logic [7:0] CELL_UNKNOWN  = 8'hFF;
  localparam logic [7:0] CELL_OCCUPIED = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH   = 2'd0,
    CFG_GRID_HEIGHT  = 2'd1,
    CFG_RADIUS_CELLS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic wr;
    logic load;
    logic setup;
    logic step;
    logic load_out;
  } owig_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } owig_sts_t;

endpackage

/* rtl/owig_ctrl.sv */
// ----------------------------------------------------------------------------
// owig_ctrl
// Controller: takes requests, sequences the window scan and holds the result
// valid flag.
// ----------------------------------------------------------------------------
module owig_ctrl import owig_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      action_i,
  output logic      in_stall_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  input  owig_sts_t sts_i,
  output owig_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (action_i == ACT_QUERY)) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: state_d = ST_SCAN;
      ST_SCAN: begin
        if (sts_i.empty) begin
          state_d = ST_DONE;
        end else if (sts_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.wr   = in_valid_i && (action_i == ACT_WRITE);
        cmd_o.load = in_valid_i && (action_i == ACT_QUERY);
      end
      ST_SETUP: cmd_o.setup = 1'b1;
      ST_SCAN:  cmd_o.step = !sts_i.empty;
      ST_DRAIN: cmd_o = '0;
      ST_DONE:  cmd_o.load_out = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

/* rtl/owig_dp.sv */
// ----------------------------------------------------------------------------
// owig_dp
// Datapath: configuration registers, grid memory, window bounds, scan
// counters, gain accumulator and result register.
// ----------------------------------------------------------------------------
module owig_dp import owig_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [7:0]              cell_row_i,
  input  logic [7:0]              cell_col_i,
  input  logic signed [7:0]       cell_value_i,
  input  owig_cmd_t               cmd_i,
  output owig_sts_t               sts_o,
  output logic signed [GAIN_W-1:0] gain_count_o
);

  logic [8:0] grid_width_q;
  logic [8:0] grid_height_q;
  logic [5:0] radius_q;

  logic [7:0] row_q;
  logic [7:0] col_q;

  logic signed [CRD_W-1:0] rad, w_lim, h_lim, cen_row, cen_col;
  logic signed [CRD_W-1:0] lo_r, hi_r, lo_c, hi_c;
  logic                    empty;

  logic [ROW_W-1:0] r_hi_q, cur_row_q;
  logic [COL_W-1:0] c_lo_q, c_hi_q, cur_col_q;
  logic             empty_q;

  logic [7:0]              mem_q [CELLS];
  logic [7:0]              rd_data_q;
  logic                    rd_vld_q;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic                    wr_ok;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_height_q <= GRID_HEIGHT_RST;
      radius_q      <= RADIUS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_WIDTH:   grid_width_q  <= cfg_data_i[8:0];
        CFG_GRID_HEIGHT:  grid_height_q <= cfg_data_i[8:0];
        CFG_RADIUS_CELLS: radius_q      <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q <= cell_row_i;
      col_q <= cell_col_i;
    end
  end

  always_comb begin
    rad = CRD_W'(radius_q);
    if (rad > CRD_W'(MAX_RADIUS)) begin
      rad = CRD_W'(MAX_RADIUS);
    end
    w_lim = CRD_W'(grid_width_q);
    if (w_lim > CRD_W'(MAX_WIDTH)) begin
      w_lim = CRD_W'(MAX_WIDTH);
    end
    h_lim = CRD_W'(grid_height_q);
    if (h_lim > CRD_W'(MAX_HEIGHT)) begin
      h_lim = CRD_W'(MAX_HEIGHT);
    end
    cen_row = CRD_W'(row_q);
    cen_col = CRD_W'(col_q);
    lo_r = cen_row - rad;
    if (lo_r < 0) begin
      lo_r = '0;
    end
    hi_r = cen_row + rad;
    if (hi_r > h_lim - CRD_W'(1)) begin
      hi_r = h_lim - CRD_W'(1);
    end
    lo_c = cen_col - rad;
    if (lo_c < 0) begin
      lo_c = '0;
    end
    hi_c = cen_col + rad - CRD_W'(1);
    if (hi_c > w_lim - CRD_W'(1)) begin
      hi_c = w_lim - CRD_W'(1);
    end
    empty = (hi_r < lo_r) || (hi_c < lo_c);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      r_hi_q    <= hi_r[ROW_W-1:0];
      c_lo_q    <= lo_c[COL_W-1:0];
      c_hi_q    <= hi_c[COL_W-1:0];
      cur_row_q <= lo_r[ROW_W-1:0];
      cur_col_q <= lo_c[COL_W-1:0];
      empty_q   <= empty;
    end else if (cmd_i.step) begin
      if (cur_col_q == c_hi_q) begin
        cur_col_q <= c_lo_q;
        cur_row_q <= ROW_W'(cur_row_q + 1'b1);
      end else begin
        cur_col_q <= COL_W'(cur_col_q + 1'b1);
      end
    end
  end

  assign sts_o.empty = empty_q;
  assign sts_o.last  = (cur_row_q == r_hi_q) && (cur_col_q == c_hi_q);

  assign wr_ok   = (CRD_W'(cell_row_i) < CRD_W'(MAX_HEIGHT)) &&
                   (CRD_W'(cell_col_i) < CRD_W'(MAX_WIDTH));
  assign wr_addr = ADDR_W'(cell_row_i) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cell_col_i);
  assign rd_addr = ADDR_W'(cur_row_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cur_col_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem_q[wr_addr] <= cell_value_i;
    end
    if (cmd_i.step) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      acc_q <= '0;
    end else if (rd_vld_q) begin
      if (rd_data_q == CELL_UNKNOWN) begin
        acc_q <= acc_q + ACC_W'(1);
      end else if (rd_data_q == CELL_OCCUPIED) begin
        acc_q <= acc_q - ACC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      gain_q <= acc_q[GAIN_W-1:0];
    end
  end

  assign gain_count_o = gain_q;

endmodule

/* rtl/occupancy_window_info_gain.sv */
// ----------------------------------------------------------------------------
// occupancy_window_info_gain
// Occupancy grid store with a windowed unknown-minus-occupied cell count.
// ----------------------------------------------------------------------------
// A request on the input channel either writes one grid cell (action 0) or
// asks for the gain of the window around a cell (action 1). Writes produce
// no result; back-to-back writes run at one per cycle. A query passes
// through the setup, scan and drain states, reading its clipped window from
// the grid memory one cell per cycle in scan, and its result register is
// loaded in the done state; an empty window goes from scan straight to done
// and reads nothing. The next request can be taken once the block is back in
// idle. With the reset radius of 20 a full window is 41 * 40 = 1640 reads.
// The input stalls from the cycle after a query is accepted until the scan
// has finished and its result is loaded. The result waits in an output
// register; while the receiver stalls it holds, and a finished query waits
// for that register to free up before the block takes the next request.
// Configuration writes are always taken. Reset restores width 256, height
// 256 and radius 20 and empties both channels; the grid contents are undefined until written.
// ----------------------------------------------------------------------------
module occupancy_window_info_gain import owig_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [7:0]               cell_row_i,
  input  logic [7:0]               cell_col_i,
  input  logic signed [7:0]        cell_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [GAIN_W-1:0] gain_count_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  owig_cmd_t cmd;
  owig_sts_t sts;

  assign cfg_ready_o = 1'b1;

  owig_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  owig_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .cell_value_i (cell_value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .gain_count_o (gain_count_o)
  );

endmodule

/* rtl/owig_chk.sv */
// ----------------------------------------------------------------------------
// owig_chk
// Port-level checker for the occupancy window gain block, bound to the top.
// ----------------------------------------------------------------------------
module owig_chk import owig_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     action_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [GAIN_W-1:0] gain_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(gain_count_o))
    else $error("stalled result changed");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_WRITE) && !out_valid_o
    |=> !out_valid_o)
    else $error("write request produced a result");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_QUERY) |=> in_stall_o ##1 in_stall_o)
    else $error("request taken while a query scan is running");

endmodule

bind occupancy_window_info_gain owig_chk u_owig_chk (.*);
